### rtl/gdc_pkg.sv
// ---------------------------------------------------------------------------
// Gate door controller package
// Shared types, state encoding, output codes and reset values.
// ---------------------------------------------------------------------------
package gdc_pkg;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned COUNTER_W   = 17;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_TIME_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_HOLD_TIME = 1'b1;

    localparam logic [CFG_DATA_W-1:0] RUN_TIME_LIMIT_RESET = 16'd180;
    localparam logic [CFG_DATA_W-1:0] OPEN_HOLD_TIME_RESET = 16'd100;

    // Fault codes.
    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_OVERTIME = 2'd1;
    localparam logic [1:0] FAULT_SWITCHES = 2'd2;

    // Remote commands.
    localparam logic [1:0] REMOTE_OPEN  = 2'd1;
    localparam logic [1:0] REMOTE_CLOSE = 2'd2;

    // Door state codes as seen on the result port.
    localparam logic [2:0] DOOR_INITIAL = 3'd0;
    localparam logic [2:0] DOOR_CLOSING = 3'd1;
    localparam logic [2:0] DOOR_OPENING = 3'd2;
    localparam logic [2:0] DOOR_CLOSED  = 3'd3;
    localparam logic [2:0] DOOR_OPEN    = 3'd4;
    localparam logic [2:0] DOOR_ERROR   = 3'd5;
    localparam logic [2:0] DOOR_STOP    = 3'd6;

    typedef enum logic [6:0] {
        ST_INITIAL = 7'b0000001,
        ST_CLOSING = 7'b0000010,
        ST_OPENING = 7'b0000100,
        ST_CLOSED  = 7'b0001000,
        ST_OPEN    = 7'b0010000,
        ST_ERROR   = 7'b0100000,
        ST_STOP    = 7'b1000000
    } gdc_state_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] run_time_limit;
        logic [CFG_DATA_W-1:0] open_hold_time;
    } gdc_cfg_t;

    typedef struct packed {
        logic       closed_switch;
        logic       open_switch;
        logic       open_button;
        logic       close_button;
        logic       emergency_button;
        logic       toggle_button;
        logic [1:0] remote_command;
    } gdc_item_t;

    typedef struct packed {
        logic       motor_open;
        logic       motor_close;
        logic       lamp;
        logic       buzzer;
        logic [2:0] door_state;
        logic [1:0] error_code;
    } gdc_result_t;

    function automatic logic [2:0] door_code(input gdc_state_t st);
        logic [2:0] code;
        unique case (st)
            ST_INITIAL: code = DOOR_INITIAL;
            ST_CLOSING: code = DOOR_CLOSING;
            ST_OPENING: code = DOOR_OPENING;
            ST_CLOSED:  code = DOOR_CLOSED;
            ST_OPEN:    code = DOOR_OPEN;
            ST_STOP:    code = DOOR_STOP;
            default:    code = DOOR_ERROR;
        endcase
        return code;
    endfunction

endpackage

### rtl/gdc_in_reg.sv
// ---------------------------------------------------------------------------
// Gate door controller input register
// Captures one poll tick and holds it until the core takes it.
// ---------------------------------------------------------------------------
module gdc_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  gdc_pkg::gdc_item_t in_item,
    input  logic              take,
    output logic              item_valid,
    output gdc_pkg::gdc_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    gdc_pkg::gdc_item_t item_reg;

    // The register frees up in the same cycle that the core takes its item.
    assign in_ready   = !valid_reg || take;
    assign valid_next = (valid_reg && !take) || in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/gdc_core.sv
// ---------------------------------------------------------------------------
// Gate door controller core
// State machine, run and hold timers, blink phase and the result register.
// ---------------------------------------------------------------------------
module gdc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  gdc_pkg::gdc_cfg_t   cfg,
    input  logic                item_valid,
    input  gdc_pkg::gdc_item_t  item,
    output logic                take,
    input  logic                out_ready,
    output logic                out_valid,
    output gdc_pkg::gdc_result_t result
);

    gdc_pkg::gdc_state_t                state_reg;
    gdc_pkg::gdc_state_t                state_next;
    logic [gdc_pkg::COUNTER_W-1:0]      run_reg;
    logic [gdc_pkg::COUNTER_W-1:0]      run_next;
    logic [gdc_pkg::COUNTER_W-1:0]      hold_reg;
    logic [gdc_pkg::COUNTER_W-1:0]      hold_next;
    logic                               blink_reg;
    logic                               blink_next;
    logic                               toggle_reg;
    logic                               toggle_next;
    logic [1:0]                         fault_reg;
    logic [1:0]                         fault_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    gdc_pkg::gdc_result_t               result_reg;
    gdc_pkg::gdc_result_t               result_next;

    logic                               lsc;
    logic                               lsa;
    logic                               any_button;
    logic                               toggle_edge;
    logic [gdc_pkg::COUNTER_W-1:0]      run_inc;
    logic [gdc_pkg::COUNTER_W-1:0]      hold_inc;
    logic                               run_over;
    logic                               hold_over;

    assign take           = item_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = take || (out_valid_reg && !out_ready);

    assign lsc         = item.closed_switch;
    assign lsa         = item.open_switch;
    assign any_button  = item.open_button || item.close_button || item.emergency_button;
    assign toggle_edge = item.toggle_button && !toggle_reg;
    assign run_inc     = run_reg + 17'd1;
    assign hold_inc    = hold_reg + 17'd1;
    assign run_over    = run_inc > {1'b0, cfg.run_time_limit};
    assign hold_over   = hold_inc > {1'b0, cfg.open_hold_time};

    always_comb
    begin
        state_next  = state_reg;
        run_next    = run_reg;
        hold_next   = hold_reg;
        blink_next  = blink_reg;
        toggle_next = toggle_reg;
        fault_next  = fault_reg;

        unique case (state_reg)
            gdc_pkg::ST_INITIAL:
            begin
                run_next = '0;
                priority if (lsc && lsa)
                begin
                    fault_next = gdc_pkg::FAULT_SWITCHES;
                    state_next = gdc_pkg::ST_ERROR;
                end
                else if (lsc)
                begin
                    state_next = gdc_pkg::ST_CLOSED;
                end
                else if (lsa)
                begin
                    state_next = gdc_pkg::ST_CLOSING;
                end
                else
                begin
                    state_next = gdc_pkg::ST_STOP;
                end
            end
            gdc_pkg::ST_CLOSING, gdc_pkg::ST_OPENING:
            begin
                blink_next = !blink_reg;
                priority if ((state_reg == gdc_pkg::ST_CLOSING) ? lsc : lsa)
                begin
                    state_next = (state_reg == gdc_pkg::ST_CLOSING) ?
                                 gdc_pkg::ST_CLOSED : gdc_pkg::ST_OPEN;
                end
                else if (any_button)
                begin
                    state_next = gdc_pkg::ST_STOP;
                end
                else
                begin
                    run_next = run_inc;
                    if (run_over)
                    begin
                        fault_next = gdc_pkg::FAULT_OVERTIME;
                        state_next = gdc_pkg::ST_ERROR;
                    end
                end
            end
            gdc_pkg::ST_CLOSED:
            begin
                if (item.open_button || item.remote_command == gdc_pkg::REMOTE_OPEN
                    || toggle_edge)
                begin
                    state_next = gdc_pkg::ST_OPENING;
                end
                toggle_next = item.toggle_button;
            end
            gdc_pkg::ST_OPEN:
            begin
                hold_next = hold_inc;
                if (hold_over || item.close_button
                    || item.remote_command == gdc_pkg::REMOTE_CLOSE || toggle_edge)
                begin
                    state_next = gdc_pkg::ST_CLOSING;
                end
                toggle_next = item.toggle_button;
            end
            gdc_pkg::ST_STOP:
            begin
                priority if ((item.open_button && !lsa)
                             || item.remote_command == gdc_pkg::REMOTE_OPEN)
                begin
                    state_next = gdc_pkg::ST_OPENING;
                end
                else if ((item.close_button && !lsc)
                         || item.remote_command == gdc_pkg::REMOTE_CLOSE)
                begin
                    state_next = gdc_pkg::ST_CLOSING;
                end
                else if (toggle_edge)
                begin
                    toggle_next = 1'b1;
                    // Only a closed door with the open switch released reopens.
                    state_next  = (lsc && !lsa) ? gdc_pkg::ST_OPENING : gdc_pkg::ST_CLOSING;
                end
                else if (lsc && lsa)
                begin
                    fault_next = gdc_pkg::FAULT_SWITCHES;
                    state_next = gdc_pkg::ST_ERROR;
                end
                else
                begin
                    toggle_next = item.toggle_button;
                end
            end
            default:
            begin
                // Error state; any corrupted state code behaves the same way.
                priority if (lsc && lsa)
                begin
                    fault_next = gdc_pkg::FAULT_SWITCHES;
                    state_next = gdc_pkg::ST_ERROR;
                end
                else if (fault_reg == gdc_pkg::FAULT_SWITCHES)
                begin
                    if (lsc != lsa)
                    begin
                        fault_next = gdc_pkg::FAULT_NONE;
                        state_next = gdc_pkg::ST_INITIAL;
                    end
                    else
                    begin
                        state_next = gdc_pkg::ST_ERROR;
                    end
                end
                else if (fault_reg == gdc_pkg::FAULT_OVERTIME)
                begin
                    state_next = gdc_pkg::ST_CLOSING;
                end
                else
                begin
                    state_next = gdc_pkg::ST_INITIAL;
                end
            end
        endcase

        // Entering a move restarts the run timer; entering open restarts the hold timer.
        if (state_next != state_reg)
        begin
            if (state_next == gdc_pkg::ST_OPENING || state_next == gdc_pkg::ST_CLOSING)
            begin
                run_next = '0;
            end
            if (state_next == gdc_pkg::ST_OPEN)
            begin
                hold_next = '0;
            end
        end
    end

    always_comb
    begin
        result_next             = '0;
        result_next.motor_open  = (state_next == gdc_pkg::ST_OPENING);
        result_next.motor_close = (state_next == gdc_pkg::ST_CLOSING);
        result_next.lamp        = ((state_next == gdc_pkg::ST_OPENING
                                    || state_next == gdc_pkg::ST_CLOSING) && blink_next)
                                  || state_next == gdc_pkg::ST_OPEN;
        result_next.buzzer      = ((state_next == gdc_pkg::ST_OPENING
                                    || state_next == gdc_pkg::ST_CLOSING) && blink_next)
                                  || state_next == gdc_pkg::ST_ERROR;
        result_next.door_state  = gdc_pkg::door_code(state_next);
        result_next.error_code  = fault_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdc_pkg::ST_INITIAL;
            run_reg       <= '0;
            hold_reg      <= '0;
            blink_reg     <= 1'b0;
            toggle_reg    <= 1'b0;
            fault_reg     <= gdc_pkg::FAULT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                state_reg  <= state_next;
                run_reg    <= run_next;
                hold_reg   <= hold_next;
                blink_reg  <= blink_next;
                toggle_reg <= toggle_next;
                fault_reg  <= fault_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

### rtl/gate_door_controller.sv
// ---------------------------------------------------------------------------
// Gate door controller
// Seven-state gate controller polled once per transaction, with run and
// hold timers, blinking lamp and buzzer drives, and fault reporting.
// ---------------------------------------------------------------------------
//  Channel  | Signals                                  | Direction
//  ---------+------------------------------------------+----------
//  in       | in_valid, in_ready, switches, buttons    | input
//  out      | out_valid, out_ready, drives, state, err | output
//  cfg      | cfg_we, cfg_index, cfg_data              | input
//
//  A transaction passes through the input register, then through the state
//  logic into the result register.
//  One transaction is accepted per cycle while the result side keeps up.
//  When out_ready is low the result is held and one more input is buffered.
//  Reset puts the controller in its initial state with default timer limits.
// ---------------------------------------------------------------------------
module gate_door_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 closed_switch,
    input  logic                                 open_switch,
    input  logic                                 open_button,
    input  logic                                 close_button,
    input  logic                                 emergency_button,
    input  logic                                 toggle_button,
    input  logic [1:0]                           remote_command,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 motor_open,
    output logic                                 motor_close,
    output logic                                 lamp,
    output logic                                 buzzer,
    output logic [2:0]                           door_state,
    output logic [1:0]                           error_code,

    input  logic                                 cfg_we,
    input  logic [gdc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [gdc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    gdc_pkg::gdc_cfg_t    cfg_reg;
    gdc_pkg::gdc_item_t   in_item;
    gdc_pkg::gdc_item_t   item;
    gdc_pkg::gdc_result_t result;
    logic                 item_valid;
    logic                 take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_time_limit <= gdc_pkg::RUN_TIME_LIMIT_RESET;
            cfg_reg.open_hold_time <= gdc_pkg::OPEN_HOLD_TIME_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gdc_pkg::CFG_RUN_TIME_LIMIT: cfg_reg.run_time_limit <= cfg_data;
                gdc_pkg::CFG_OPEN_HOLD_TIME: cfg_reg.open_hold_time <= cfg_data;
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_item.closed_switch    = closed_switch;
        in_item.open_switch      = open_switch;
        in_item.open_button      = open_button;
        in_item.close_button     = close_button;
        in_item.emergency_button = emergency_button;
        in_item.toggle_button    = toggle_button;
        in_item.remote_command   = remote_command;
    end

    gdc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    gdc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .result     (result)
    );

    assign motor_open  = result.motor_open;
    assign motor_close = result.motor_close;
    assign lamp        = result.lamp;
    assign buzzer      = result.buzzer;
    assign door_state  = result.door_state;
    assign error_code  = result.error_code;

endmodule

### sim/tb_gate_door_controller.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Gate door controller testbench
// Drives poll ticks through the valid/ready input channel and predicts every
// result with a cycle-free model of the gate state machine, its run and hold
// timers, blink phase, push-push edge and fault code. Results are checked in
// order, field by field, under random idling on both sides, a long result
// stall, and several timer settings that include both extremes.
// ---------------------------------------------------------------------------
module tb_gate_door_controller;

    localparam logic [1:0] REMOTE_NONE    = 2'd0;
    localparam logic [1:0] REMOTE_IGNORED = 2'd3;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef enum int { AT_CLOSED, AT_OPEN, AT_MIDDLE } door_pos_t;
    typedef enum int { SEG_REST, SEG_TRAVEL, SEG_NOISE, SEG_BOTH } segment_t;
    typedef enum int { PICK_OPEN, PICK_CLOSE, PICK_EMERGENCY, PICK_REMOTE, PICK_PUSH } pick_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                many_in_valid_unused;
    logic                in_valid = 1'b0;
    logic                in_ready;
    gdc_pkg::gdc_item_t  tick_out = '0;

    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       motor_open;
    logic       motor_close;
    logic       lamp;
    logic       buzzer;
    logic [2:0] door_state;
    logic [1:0] error_code;

    logic                            cfg_we = 1'b0;
    logic [gdc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [gdc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Predicted controller state and its copy of the timer limits.
    gdc_pkg::gdc_state_t             gate_state;
    logic [gdc_pkg::COUNTER_W-1:0]   run_ticks;
    logic [gdc_pkg::COUNTER_W-1:0]   hold_ticks;
    logic                            blink;
    logic                            push_prev;
    logic [1:0]                      fault;
    logic [gdc_pkg::CFG_DATA_W-1:0]  run_limit;
    logic [gdc_pkg::CFG_DATA_W-1:0]  hold_limit;

    gdc_pkg::gdc_item_t   gate_ticks_pending[$];
    gdc_pkg::gdc_result_t door_results_due[$];
    gdc_pkg::gdc_result_t predicted;
    gdc_pkg::gdc_result_t wanted;

    int  mismatches = 0;
    int  results_seen = 0;
    int  in_gap = 0;
    int  ready_hold = 0;
    int  idle_cycles = 0;
    bit  quiet_tail = 1'b0;

    gate_door_controller uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .closed_switch    (tick_out.closed_switch),
        .open_switch      (tick_out.open_switch),
        .open_button      (tick_out.open_button),
        .close_button     (tick_out.close_button),
        .emergency_button (tick_out.emergency_button),
        .toggle_button    (tick_out.toggle_button),
        .remote_command   (tick_out.remote_command),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .motor_open       (motor_open),
        .motor_close      (motor_close),
        .lamp             (lamp),
        .buzzer           (buzzer),
        .door_state       (door_state),
        .error_code       (error_code),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic predict_gate_tick(input gdc_pkg::gdc_item_t t,
                                     output gdc_pkg::gdc_result_t res);
        gdc_pkg::gdc_state_t nxt;
        logic                push_edge;
        logic                any_button;
        logic                moving;
        nxt = gate_state;
        push_edge = t.toggle_button && !push_prev;
        any_button = t.open_button || t.close_button || t.emergency_button;
        case (gate_state)
            gdc_pkg::ST_INITIAL:
            begin
                run_ticks = '0;
                if (t.closed_switch && t.open_switch)
                begin
                    fault = gdc_pkg::FAULT_SWITCHES;
                    nxt = gdc_pkg::ST_ERROR;
                end
                else if (t.closed_switch)
                    nxt = gdc_pkg::ST_CLOSED;
                else if (t.open_switch)
                    nxt = gdc_pkg::ST_CLOSING;
                else
                    nxt = gdc_pkg::ST_STOP;
            end
            gdc_pkg::ST_CLOSING, gdc_pkg::ST_OPENING:
            begin
                blink = ~blink;
                if (gate_state == gdc_pkg::ST_CLOSING ? t.closed_switch : t.open_switch)
                    nxt = (gate_state == gdc_pkg::ST_CLOSING) ?
                          gdc_pkg::ST_CLOSED : gdc_pkg::ST_OPEN;
                else if (any_button)
                    nxt = gdc_pkg::ST_STOP;
                else
                begin
                    run_ticks = run_ticks + 1'b1;
                    if (run_ticks > run_limit)
                    begin
                        fault = gdc_pkg::FAULT_OVERTIME;
                        nxt = gdc_pkg::ST_ERROR;
                    end
                end
            end
            gdc_pkg::ST_CLOSED:
            begin
                if (t.open_button || t.remote_command == gdc_pkg::REMOTE_OPEN || push_edge)
                    nxt = gdc_pkg::ST_OPENING;
                push_prev = t.toggle_button;
            end
            gdc_pkg::ST_OPEN:
            begin
                hold_ticks = hold_ticks + 1'b1;
                if (hold_ticks > hold_limit || t.close_button ||
                    t.remote_command == gdc_pkg::REMOTE_CLOSE || push_edge)
                    nxt = gdc_pkg::ST_CLOSING;
                push_prev = t.toggle_button;
            end
            gdc_pkg::ST_STOP:
            begin
                if ((t.open_button && !t.open_switch) ||
                    t.remote_command == gdc_pkg::REMOTE_OPEN)
                    nxt = gdc_pkg::ST_OPENING;
                else if ((t.close_button && !t.closed_switch) ||
                         t.remote_command == gdc_pkg::REMOTE_CLOSE)
                    nxt = gdc_pkg::ST_CLOSING;
                else if (push_edge)
                begin
                    // A push-push edge reverses away from whichever end is reached.
                    push_prev = 1'b1;
                    nxt = (!t.open_switch && t.closed_switch) ?
                          gdc_pkg::ST_OPENING : gdc_pkg::ST_CLOSING;
                end
                else if (t.closed_switch && t.open_switch)
                begin
                    fault = gdc_pkg::FAULT_SWITCHES;
                    nxt = gdc_pkg::ST_ERROR;
                end
                else
                    push_prev = t.toggle_button;
            end
            default:
            begin
                if (t.closed_switch && t.open_switch)
                    fault = gdc_pkg::FAULT_SWITCHES;
                else if (fault == gdc_pkg::FAULT_SWITCHES)
                begin
                    if (t.closed_switch != t.open_switch)
                    begin
                        fault = gdc_pkg::FAULT_NONE;
                        nxt = gdc_pkg::ST_INITIAL;
                    end
                end
                else if (fault == gdc_pkg::FAULT_OVERTIME)
                    nxt = gdc_pkg::ST_CLOSING;
                else
                    nxt = gdc_pkg::ST_INITIAL;
            end
        endcase

        if (nxt != gate_state)
        begin
            if (nxt == gdc_pkg::ST_OPENING || nxt == gdc_pkg::ST_CLOSING)
                run_ticks = '0;
            if (nxt == gdc_pkg::ST_OPEN)
                hold_ticks = '0;
        end
        gate_state = nxt;

        moving = (nxt == gdc_pkg::ST_OPENING) || (nxt == gdc_pkg::ST_CLOSING);
        res.motor_open = (nxt == gdc_pkg::ST_OPENING);
        res.motor_close = (nxt == gdc_pkg::ST_CLOSING);
        res.lamp = moving ? blink : (nxt == gdc_pkg::ST_OPEN);
        res.buzzer = moving ? blink : (nxt == gdc_pkg::ST_ERROR);
        case (nxt)
            gdc_pkg::ST_INITIAL: res.door_state = gdc_pkg::DOOR_INITIAL;
            gdc_pkg::ST_CLOSING: res.door_state = gdc_pkg::DOOR_CLOSING;
            gdc_pkg::ST_OPENING: res.door_state = gdc_pkg::DOOR_OPENING;
            gdc_pkg::ST_CLOSED:  res.door_state = gdc_pkg::DOOR_CLOSED;
            gdc_pkg::ST_OPEN:    res.door_state = gdc_pkg::DOOR_OPEN;
            gdc_pkg::ST_STOP:    res.door_state = gdc_pkg::DOOR_STOP;
            default:             res.door_state = gdc_pkg::DOOR_ERROR;
        endcase
        res.error_code = fault;
    endtask

    task automatic check_field(input string name, input logic [2:0] want,
                               input logic [2:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    function automatic gdc_pkg::gdc_item_t tick_of(input logic c, input logic o,
                                                   input logic ob, input logic cb,
                                                   input logic eb, input logic tb,
                                                   input logic [1:0] rc);
        gdc_pkg::gdc_item_t t;
        t.closed_switch = c;
        t.open_switch = o;
        t.open_button = ob;
        t.close_button = cb;
        t.emergency_button = eb;
        t.toggle_button = tb;
        t.remote_command = rc;
        return t;
    endfunction

    // Sender: holds each transaction until accepted, with random gaps between.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tick_out <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                gate_ticks_pending.delete(0);
            if (in_gap == 0 && !quiet_tail && $urandom_range(0, 15) == 0)
                in_gap = $urandom_range(1, 16);
            if (in_gap > 0 && !quiet_tail)
            begin
                in_gap = in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (gate_ticks_pending.size() != 0)
            begin
                in_valid <= 1'b1;
                tick_out <= gate_ticks_pending[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: predicts on accepted inputs, checks accepted results, and
    // stalls the result side at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_gate_tick(tick_out, predicted);
                door_results_due.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                results_seen = results_seen + 1;
                if (door_results_due.size() == 0)
                begin
                    $error("result with no transaction pending: door_state %0d", door_state);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    wanted = door_results_due.pop_front();
                    check_field("motor_open", 3'(wanted.motor_open), 3'(motor_open));
                    check_field("motor_close", 3'(wanted.motor_close), 3'(motor_close));
                    check_field("lamp", 3'(wanted.lamp), 3'(lamp));
                    check_field("buzzer", 3'(wanted.buzzer), 3'(buzzer));
                    check_field("door_state", wanted.door_state, door_state);
                    check_field("error_code", 3'(wanted.error_code), 3'(error_code));
                end
                // One long stall lets the block fill up and push back on its input.
                if (results_seen == LONG_HOLD_AT)
                    ready_hold = LONG_HOLD_CYCLES;
            end
            if (ready_hold == 0 && !quiet_tail && $urandom_range(0, 15) == 0)
                ready_hold = $urandom_range(1, 16);
            if (ready_hold > 0 && !quiet_tail)
            begin
                ready_hold = ready_hold - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_gate_door_controller NOT OK");
            $finish;
        end
    end

    task automatic write_gate_cfg(input logic [gdc_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [gdc_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == gdc_pkg::CFG_RUN_TIME_LIMIT)
            run_limit = val;
        else
            hold_limit = val;
    endtask

    task automatic drain_gate();
        while (gate_ticks_pending.size() != 0 || door_results_due.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Mostly plausible door behavior: resting at an end or in between with the
    // occasional command, travels ending on a limit switch, plus raw noise and
    // both-switch faults.
    task automatic queue_random_ticks(input int count);
        gdc_pkg::gdc_item_t t;
        logic [7:0]         raw;
        door_pos_t          pos;
        segment_t           seg;
        int                 made;
        int                 roll;
        int                 len;
        int                 push_hold;
        int                 travel_max;
        made = 0;
        push_hold = 0;
        pos = AT_MIDDLE;
        while (made < count)
        begin
            roll = $urandom_range(0, 9);
            seg = (roll < 5) ? SEG_REST : (roll < 8) ? SEG_TRAVEL :
                  (roll == 8) ? SEG_NOISE : SEG_BOTH;
            travel_max = (run_limit < 37) ? int'(run_limit) + 4 : 40;
            case (seg)
                SEG_REST:
                begin
                    pos = door_pos_t'($urandom_range(0, 2));
                    len = $urandom_range(1, 20);
                end
                SEG_TRAVEL:
                begin
                    pos = AT_MIDDLE;
                    len = $urandom_range(1, travel_max);
                end
                default:
                    len = $urandom_range(1, 4);
            endcase
            repeat (len)
            begin
                if (seg == SEG_NOISE)
                begin
                    raw = 8'($urandom_range(0, 255));
                    t = raw;
                end
                else if (seg == SEG_BOTH)
                    t = tick_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                2'($urandom_range(0, 3)));
                else
                begin
                    t = tick_of(pos == AT_CLOSED, pos == AT_OPEN, 1'b0, 1'b0, 1'b0, 1'b0,
                                REMOTE_NONE);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        case (pick_t'($urandom_range(0, 4)))
                            PICK_OPEN:      t.open_button = 1'b1;
                            PICK_CLOSE:     t.close_button = 1'b1;
                            PICK_EMERGENCY: t.emergency_button = 1'b1;
                            PICK_REMOTE:    t.remote_command = 2'($urandom_range(1, 3));
                            default:        push_hold = $urandom_range(1, 3);
                        endcase
                    end
                    if (push_hold > 0)
                    begin
                        t.toggle_button = 1'b1;
                        push_hold = push_hold - 1;
                    end
                end
                gate_ticks_pending.push_back(t);
                made = made + 1;
            end
            if (seg == SEG_TRAVEL)
            begin
                if ($urandom_range(0, 1) == 0)
                    t = tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE);
                else
                    t = tick_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE);
                gate_ticks_pending.push_back(t);
                made = made + 1;
            end
        end
    endtask

    task automatic run_gate_phase(input logic [gdc_pkg::CFG_DATA_W-1:0] run_val,
                                  input logic [gdc_pkg::CFG_DATA_W-1:0] hold_val,
                                  input int count);
        write_gate_cfg(gdc_pkg::CFG_RUN_TIME_LIMIT, run_val);
        write_gate_cfg(gdc_pkg::CFG_OPEN_HOLD_TIME, hold_val);
        @(negedge clk);
        queue_random_ticks(count);
        drain_gate();
    endtask

    initial
    begin
        gate_state = gdc_pkg::ST_INITIAL;
        run_ticks = '0;
        hold_ticks = '0;
        blink = 1'b0;
        push_prev = 1'b0;
        fault = gdc_pkg::FAULT_NONE;
        run_limit = gdc_pkg::RUN_TIME_LIMIT_RESET;
        hold_limit = gdc_pkg::OPEN_HOLD_TIME_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk through every state and exit with the reset timer limits.
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                             REMOTE_IGNORED));
        gate_ticks_pending.push_back(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                             gdc_pkg::REMOTE_OPEN));
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                             gdc_pkg::REMOTE_CLOSE));
        gate_ticks_pending.push_back(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, REMOTE_NONE));
        gate_ticks_pending.push_back(tick_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, REMOTE_NONE));
        repeat (4)
            gate_ticks_pending.push_back(tick_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                                 REMOTE_IGNORED));
        drain_gate();

        run_gate_phase('0, '0, 100);
        run_gate_phase('1, '1, 100);
        repeat (4)
            run_gate_phase(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)), 130);
        quiet_tail = 1'b1;
        run_gate_phase(16'($urandom_range(1, 40)), 16'($urandom_range(0, 40)), 100);

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("tb_gate_door_controller OK");
        else
            $display("tb_gate_door_controller NOT OK");
        $finish;
    end

endmodule
